### sv/iwsid_pkg.sv
`default_nettype none
package iwsid_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 17;
    localparam int LANES    = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SAMPLE_W-1:0]        t_swing;
    typedef logic [THR_W-1:0]           t_thr;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO      = 2'd3;

    localparam t_thr RST_ACCEL_BIG = 17'd16383;
    localparam t_thr RST_ACCEL     = 17'd9215;
    localparam t_thr RST_GYRO      = 17'd6553;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

endpackage
`default_nettype wire

### sv/iwsid_in_if.sv
`default_nettype none
interface iwsid_in_if;
    logic                valid;
    logic                ready;
    logic                opcode;
    iwsid_pkg::t_sample  accel_x;
    iwsid_pkg::t_sample  accel_y;
    iwsid_pkg::t_sample  accel_z;
    iwsid_pkg::t_sample  gyro_x;
    iwsid_pkg::t_sample  gyro_y;
    iwsid_pkg::t_sample  gyro_z;

    modport source (output valid, opcode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, opcode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface
`default_nettype wire

### sv/iwsid_out_if.sv
`default_nettype none
interface iwsid_out_if;
    logic               valid;
    logic               ready;
    logic               alarm;
    logic               window_full;
    iwsid_pkg::t_swing  swing_ax;
    iwsid_pkg::t_swing  swing_ay;
    iwsid_pkg::t_swing  swing_az;
    iwsid_pkg::t_swing  swing_gx;
    iwsid_pkg::t_swing  swing_gy;
    iwsid_pkg::t_swing  swing_gz;

    modport source (output valid, alarm, window_full, swing_ax, swing_ay, swing_az,
                    swing_gx, swing_gy, swing_gz, input ready);
    modport sink   (input valid, alarm, window_full, swing_ax, swing_ay, swing_az,
                    swing_gx, swing_gy, swing_gz, output ready);
endinterface
`default_nettype wire

### sv/iwsid_ram.sv
`default_nettype none
module iwsid_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/imu_window_swing_impact_detector.sv
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_item    in   valid/ready   opcode, accel_x/y/z, gyro_x/y/z (signed 16)
// o_result  out  valid/ready   alarm, window_full, swing_ax..swing_gz (unsigned 16)
// i_cfg_*   in   write enable  index 0..3, 17-bit data
//
// Clear items, ignored samples and samples that leave the window short give
// their result in the cycle after acceptance. A sample that fills the window or
// finds it full walks the window first: one window RAM read per entry through
// a single read port, then swing subtract, then threshold decision.
// Reset is synchronous, active low; the window RAM is not cleared.
// i_item.ready is low while a result waits on o_result or a walk is running.
module imu_window_swing_impact_detector #(
    parameter int WINDOW_DEPTH = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [iwsid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [iwsid_pkg::THR_W-1:0]     i_cfg_data,
    iwsid_in_if.sink                            i_item,
    iwsid_out_if.source                         o_result
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int LANES  = iwsid_pkg::LANES;
    localparam int SW     = iwsid_pkg::SAMPLE_W;
    localparam int ROW_W  = LANES * SW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_SWING  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic                  r_enable;
    iwsid_pkg::t_thr       r_thr_big;
    iwsid_pkg::t_thr       r_thr_acc;
    iwsid_pkg::t_thr       r_thr_gyr;

    logic [2:0]            r_state;
    logic [IDX_W-1:0]      r_slot;
    logic [FILL_W-1:0]     r_fill;
    logic                  r_alarm;
    logic [IDX_W-1:0]      r_k;
    logic                  r_dv;
    iwsid_pkg::t_sample    r_hi [LANES];
    iwsid_pkg::t_sample    r_lo [LANES];
    iwsid_pkg::t_swing     r_swing [LANES];

    logic                  r_out_valid;
    logic                  r_o_alarm;
    logic                  r_o_full;

    logic                  acc;
    logic                  ram_we;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    logic                  becomes_full;
    logic                  hit;

    assign acc    = i_item.valid && i_item.ready;
    assign ram_we = acc && (i_item.opcode == iwsid_pkg::OP_SAMPLE) && r_enable && !r_alarm;
    assign ram_wdata = {i_item.gyro_z, i_item.gyro_y, i_item.gyro_x,
                        i_item.accel_z, i_item.accel_y, i_item.accel_x};
    assign becomes_full = (r_fill == FILL_W'(WINDOW_DEPTH))
                       || (r_fill == FILL_W'(WINDOW_DEPTH - 1));

    iwsid_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_k),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        hit = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if ({1'b0, r_swing[a]} > r_thr_big) begin
                hit = 1'b1;
            end
            if (({1'b0, r_swing[a]} > r_thr_acc) && ({1'b0, r_swing[a+3]} > r_thr_gyr)) begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_thr_big <= iwsid_pkg::RST_ACCEL_BIG;
            r_thr_acc <= iwsid_pkg::RST_ACCEL;
            r_thr_gyr <= iwsid_pkg::RST_GYRO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iwsid_pkg::REG_ENABLE:    r_enable  <= i_cfg_data[0];
                iwsid_pkg::REG_ACCEL_BIG: r_thr_big <= i_cfg_data;
                iwsid_pkg::REG_ACCEL:     r_thr_acc <= i_cfg_data;
                iwsid_pkg::REG_GYRO:      r_thr_gyr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            for (int i = 0; i < LANES; i++) begin
                if ($signed(ram_rdata[SW*i +: SW]) > r_hi[i]) begin
                    r_hi[i] <= ram_rdata[SW*i +: SW];
                end
                if ($signed(ram_rdata[SW*i +: SW]) < r_lo[i]) begin
                    r_lo[i] <= ram_rdata[SW*i +: SW];
                end
            end
        end
        if (ram_we) begin
            for (int i = 0; i < LANES; i++) begin
                r_hi[i] <= iwsid_pkg::SAMPLE_MIN;
                r_lo[i] <= iwsid_pkg::SAMPLE_MAX;
            end
        end
        if (r_state == S_SWING) begin
            for (int i = 0; i < LANES; i++) begin
                r_swing[i] <= SW'({r_hi[i][SW-1], r_hi[i]} - {r_lo[i][SW-1], r_lo[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_alarm     <= 1'b0;
            r_k         <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_alarm   <= 1'b0;
            r_o_full    <= 1'b0;
        end else begin
            r_dv <= (r_state == S_READ);
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_item.opcode == iwsid_pkg::OP_CLEAR) begin
                            r_slot      <= '0;
                            r_fill      <= '0;
                            r_alarm     <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_o_alarm   <= 1'b0;
                            r_o_full    <= 1'b0;
                        end else if (ram_we) begin
                            r_slot <= (r_slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                            : r_slot + 1'b1;
                            if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                                r_fill <= r_fill + 1'b1;
                            end
                            if (becomes_full) begin
                                r_state <= S_READ;
                                r_k     <= '0;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_o_alarm   <= r_alarm;
                                r_o_full    <= 1'b0;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            r_o_alarm   <= r_alarm;
                            r_o_full    <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    if (r_k == IDX_W'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_SWING;
                end
                S_SWING: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_alarm     <= hit;
                    r_out_valid <= 1'b1;
                    r_o_alarm   <= hit;
                    r_o_full    <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready         = i_rst_n && (r_state == S_IDLE) && !r_out_valid;
    assign o_result.valid       = r_out_valid;
    assign o_result.alarm       = r_o_alarm;
    assign o_result.window_full = r_o_full;
    assign o_result.swing_ax    = r_o_full ? r_swing[0] : '0;
    assign o_result.swing_ay    = r_o_full ? r_swing[1] : '0;
    assign o_result.swing_az    = r_o_full ? r_swing[2] : '0;
    assign o_result.swing_gx    = r_o_full ? r_swing[3] : '0;
    assign o_result.swing_gy    = r_o_full ? r_swing[4] : '0;
    assign o_result.swing_gz    = r_o_full ? r_swing[5] : '0;

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_item.opcode == iwsid_pkg::OP_CLEAR) |=> o_result.valid && !o_result.alarm)
        else $error("clear item did not give a cleared result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_full_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.window_full |-> r_fill == FILL_W'(WINDOW_DEPTH))
        else $error("window_full result without a full window");

    a_alarm_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm |=> r_alarm || $past(acc && (i_item.opcode == iwsid_pkg::OP_CLEAR)))
        else $error("alarm dropped without a clear item");

endmodule
`default_nettype wire

### tb/iwsid_swing_checker.sv
`default_nettype none
module iwsid_swing_checker #(
    parameter int WINDOW_DEPTH = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [iwsid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [iwsid_pkg::THR_W-1:0]     i_cfg_data,
    iwsid_in_if                                  i_item,
    iwsid_out_if                                 i_result,
    output int                                   o_pending,
    output int                                   o_mismatches
);

    localparam int MAX_REPORTS = 10;
    localparam int LANES       = iwsid_pkg::LANES;

    typedef struct packed {
        logic                          alarm;
        logic                          window_full;
        iwsid_pkg::t_swing [LANES-1:0] swing;
    } t_swing_report;

    logic            armed = 1'b0;
    iwsid_pkg::t_thr big_thr = iwsid_pkg::RST_ACCEL_BIG;
    iwsid_pkg::t_thr accel_thr = iwsid_pkg::RST_ACCEL;
    iwsid_pkg::t_thr gyro_thr = iwsid_pkg::RST_GYRO;
    int              win [WINDOW_DEPTH][LANES];
    int              write_slot = 0;
    int              fill_count = 0;
    logic            alarm_latched = 1'b0;
    int              sample_lanes [LANES];
    t_swing_report   swing_expected [$];
    int              mismatch_count = 0;

    string lane_name [LANES] = '{"swing_ax", "swing_ay", "swing_az",
                                 "swing_gx", "swing_gy", "swing_gz"};

    function automatic t_swing_report predict_swing(input logic op);
        t_swing_report rep;
        int hi;
        int lo;
        logic hit;
        rep = '0;
        hit = 1'b0;
        if (op == iwsid_pkg::OP_CLEAR) begin
            write_slot = 0;
            fill_count = 0;
            alarm_latched = 1'b0;
        end else if (armed && !alarm_latched) begin
            for (int l = 0; l < LANES; l++) begin
                win[write_slot][l] = sample_lanes[l];
            end
            write_slot = (write_slot + 1 < WINDOW_DEPTH) ? write_slot + 1 : 0;
            if (fill_count < WINDOW_DEPTH) begin
                fill_count++;
            end
            if (fill_count >= WINDOW_DEPTH) begin
                rep.window_full = 1'b1;
                for (int l = 0; l < LANES; l++) begin
                    hi = -32768;
                    lo = 32767;
                    for (int k = 0; k < WINDOW_DEPTH; k++) begin
                        if (win[k][l] > hi) hi = win[k][l];
                        if (win[k][l] < lo) lo = win[k][l];
                    end
                    rep.swing[l] = iwsid_pkg::t_swing'(hi - lo);
                end
                for (int a = 0; a < 3; a++) begin
                    if (rep.swing[a] > big_thr) hit = 1'b1;
                    if (rep.swing[a] > accel_thr && rep.swing[a+3] > gyro_thr) hit = 1'b1;
                end
                if (hit) begin
                    alarm_latched = 1'b1;
                end
            end
        end
        rep.alarm = alarm_latched;
        return rep;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    task automatic check_result();
        t_swing_report want;
        t_swing_report got;
        got.alarm = i_result.alarm;
        got.window_full = i_result.window_full;
        got.swing[0] = i_result.swing_ax;
        got.swing[1] = i_result.swing_ay;
        got.swing[2] = i_result.swing_az;
        got.swing[3] = i_result.swing_gx;
        got.swing[4] = i_result.swing_gy;
        got.swing[5] = i_result.swing_gz;
        if (swing_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("unexpected result: alarm %0b window_full %0b", got.alarm,
                         got.window_full);
            end
        end else begin
            want = swing_expected.pop_front();
            if (got.alarm !== want.alarm) note_mismatch("alarm", want.alarm, got.alarm);
            if (got.window_full !== want.window_full) begin
                note_mismatch("window_full", want.window_full, got.window_full);
            end
            for (int l = 0; l < LANES; l++) begin
                if (got.swing[l] !== want.swing[l]) begin
                    note_mismatch(lane_name[l], want.swing[l], got.swing[l]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            armed = 1'b0;
            big_thr = iwsid_pkg::RST_ACCEL_BIG;
            accel_thr = iwsid_pkg::RST_ACCEL;
            gyro_thr = iwsid_pkg::RST_GYRO;
            write_slot = 0;
            fill_count = 0;
            alarm_latched = 1'b0;
            swing_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iwsid_pkg::REG_ENABLE:    armed = i_cfg_data[0];
                    iwsid_pkg::REG_ACCEL_BIG: big_thr = i_cfg_data;
                    iwsid_pkg::REG_ACCEL:     accel_thr = i_cfg_data;
                    iwsid_pkg::REG_GYRO:      gyro_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                check_result();
            end
            if (i_item.valid && i_item.ready) begin
                sample_lanes[0] = i_item.accel_x;
                sample_lanes[1] = i_item.accel_y;
                sample_lanes[2] = i_item.accel_z;
                sample_lanes[3] = i_item.gyro_x;
                sample_lanes[4] = i_item.gyro_y;
                sample_lanes[5] = i_item.gyro_z;
                swing_expected.push_back(predict_swing(i_item.opcode));
            end
        end
        o_pending <= swing_expected.size();
        o_mismatches <= mismatch_count;
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int LANES          = iwsid_pkg::LANES;
    localparam iwsid_pkg::t_thr THR_MAX = 17'h1FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [iwsid_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    iwsid_pkg::t_thr i_cfg_data;

    int pending;
    int mismatches;
    int stall_cycles = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    int seq_mode;
    int seq_amp;
    int seq_base [LANES];

    iwsid_in_if  item_bus ();
    iwsid_out_if result_bus ();

    imu_window_swing_impact_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    iwsid_swing_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item_bus),
        .i_result     (result_bus),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        forever begin
            if (hold_off) begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                result_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic int any_sample();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int jitter(input int base, input int amp);
        int v;
        v = base + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    task automatic send_item(input logic op, input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz);
        item_bus.valid   <= 1'b1;
        item_bus.opcode  <= op;
        item_bus.accel_x <= iwsid_pkg::t_sample'(ax);
        item_bus.accel_y <= iwsid_pkg::t_sample'(ay);
        item_bus.accel_z <= iwsid_pkg::t_sample'(az);
        item_bus.gyro_x  <= iwsid_pkg::t_sample'(gx);
        item_bus.gyro_y  <= iwsid_pkg::t_sample'(gy);
        item_bus.gyro_z  <= iwsid_pkg::t_sample'(gz);
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_clear();
        send_item(iwsid_pkg::OP_CLEAR, any_sample(), any_sample(), any_sample(),
                  any_sample(), any_sample(), any_sample());
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_regs(input iwsid_pkg::t_thr en, input iwsid_pkg::t_thr big,
                            input iwsid_pkg::t_thr acc, input iwsid_pkg::t_thr gyr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= iwsid_pkg::REG_ENABLE;
        i_cfg_data <= en;
        @(posedge i_clk);
        i_cfg_idx  <= iwsid_pkg::REG_ACCEL_BIG;
        i_cfg_data <= big;
        @(posedge i_clk);
        i_cfg_idx  <= iwsid_pkg::REG_ACCEL;
        i_cfg_data <= acc;
        @(posedge i_clk);
        i_cfg_idx  <= iwsid_pkg::REG_GYRO;
        i_cfg_data <= gyr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pick_sequence();
        int amps [3];
        amps = '{256, 4096, 12000};
        seq_mode = $urandom_range(0, 3);
        seq_amp = amps[$urandom_range(0, 2)];
        for (int l = 0; l < LANES; l++) begin
            seq_base[l] = int'($urandom_range(0, 32000)) - 16000;
        end
    endtask

    task automatic send_random_sample();
        int lv [LANES];
        for (int l = 0; l < LANES; l++) begin
            lv[l] = (seq_mode == 0) ? any_sample() : jitter(seq_base[l], seq_amp);
        end
        send_item(iwsid_pkg::OP_SAMPLE, lv[0], lv[1], lv[2], lv[3], lv[4], lv[5]);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = iwsid_pkg::REG_ENABLE;
        i_cfg_data       = '0;
        item_bus.valid   = 1'b0;
        item_bus.opcode  = iwsid_pkg::OP_SAMPLE;
        item_bus.accel_x = '0;
        item_bus.accel_y = '0;
        item_bus.accel_z = '0;
        item_bus.gyro_x  = '0;
        item_bus.gyro_y  = '0;
        item_bus.gyro_z  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset: samples ignored, clear still works
        send_item(iwsid_pkg::OP_SAMPLE, iwsid_pkg::SAMPLE_MAX, iwsid_pkg::SAMPLE_MIN,
                  1, -1, 100, -100);
        send_item(iwsid_pkg::OP_SAMPLE, iwsid_pkg::SAMPLE_MIN, iwsid_pkg::SAMPLE_MAX,
                  0, 0, 0, 0);
        send_clear();
        drain();
        set_regs(17'd1, iwsid_pkg::RST_ACCEL_BIG, iwsid_pkg::RST_ACCEL, iwsid_pkg::RST_GYRO);

        // full-scale swing, then a latched alarm ignores the next sample
        for (int i = 0; i < 5; i++) begin
            if (i % 2 == 0) begin
                send_item(iwsid_pkg::OP_SAMPLE, iwsid_pkg::SAMPLE_MAX, iwsid_pkg::SAMPLE_MAX,
                          iwsid_pkg::SAMPLE_MAX, iwsid_pkg::SAMPLE_MAX,
                          iwsid_pkg::SAMPLE_MAX, iwsid_pkg::SAMPLE_MAX);
            end else begin
                send_item(iwsid_pkg::OP_SAMPLE, iwsid_pkg::SAMPLE_MIN, iwsid_pkg::SAMPLE_MIN,
                          iwsid_pkg::SAMPLE_MIN, iwsid_pkg::SAMPLE_MIN,
                          iwsid_pkg::SAMPLE_MIN, iwsid_pkg::SAMPLE_MIN);
            end
        end
        send_item(iwsid_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0);
        send_clear();

        // thresholds at the boundary, then combined accel and gyro swing
        for (int i = 0; i < 5; i++) send_item(iwsid_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0);
        send_item(iwsid_pkg::OP_SAMPLE, 9215, 0, 16383, iwsid_pkg::SAMPLE_MAX, 0, 0);
        send_item(iwsid_pkg::OP_SAMPLE, 0, 9216, 0, 0, -6554, 0);
        send_clear();

        // accel swing alone above the big threshold
        for (int i = 0; i < 4; i++) send_item(iwsid_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0);
        send_item(iwsid_pkg::OP_SAMPLE, -16384, 0, 0, 0, 0, 0);
        send_clear();

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: set_regs(17'd1, '0, '0, '0);
                1: set_regs(THR_MAX, THR_MAX, THR_MAX, THR_MAX);
                2: set_regs(17'd1, iwsid_pkg::RST_ACCEL_BIG, iwsid_pkg::RST_ACCEL,
                            iwsid_pkg::RST_GYRO);
                3: set_regs(17'h1FFFE, iwsid_pkg::RST_ACCEL_BIG, iwsid_pkg::RST_ACCEL,
                            iwsid_pkg::RST_GYRO);
                default: set_regs(17'd1, iwsid_pkg::t_thr'($urandom_range(4000, 70000)),
                                  iwsid_pkg::t_thr'($urandom_range(1000, 40000)),
                                  iwsid_pkg::t_thr'($urandom_range(1000, 40000)));
            endcase
            if (p == 4) hold_off = 1'b1;
            if (p == PHASES - 1) calm = 1'b1;
            pick_sequence();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_clear();
                    pick_sequence();
                end else begin
                    send_random_sample();
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

### imu_window_swing_impact_detector.f
sv/iwsid_pkg.sv
sv/iwsid_in_if.sv
sv/iwsid_out_if.sv
sv/iwsid_ram.sv
sv/imu_window_swing_impact_detector.sv
tb/iwsid_swing_checker.sv
tb/tb_top.sv
